@@ hdl/lbm_pkg.sv @@
`timescale 1ns / 1ps

package lbm_pkg;

    // Omega register format: unsigned Q2.14.
    localparam int OMEGA_W    = 16;
    localparam int OMEGA_FRAC = 14;
    localparam logic [OMEGA_W-1:0] RELAX_RATE_RESET = 16'd16384;

    // Integer bits of the value format (Q3.FRAC plus sign).
    localparam int INT_BITS = 4;

    localparam int NUM_DIR = 9;

    // Lattice directions: rest, E, N, W, S, NE, NW, SW, SE.
    localparam logic signed [1:0] DIR_X [0:NUM_DIR-1] = '{
        2'sd0, 2'sd1, 2'sd0, -2'sd1, 2'sd0, 2'sd1, -2'sd1, -2'sd1, 2'sd1
    };
    localparam logic signed [1:0] DIR_Y [0:NUM_DIR-1] = '{
        2'sd0, 2'sd0, 2'sd1, 2'sd0, -2'sd1, 2'sd1, 2'sd1, -2'sd1, -2'sd1
    };

endpackage

@@ hdl/d2q9_bgk_node_collision.sv @@
`timescale 1ns / 1ps

// D2Q9 BGK collision of one lattice node with a Shan-Chen velocity shift, in
// signed fixed point with VALUE_WIDTH-4 fraction bits. The block takes one node
// per clock while the output is not stalled; the four restoring dividers in
// its pipeline resolve one quotient bit per pipeline stage. A stall on the
// output holds the whole pipeline. Omega must be written through the
// configuration port only while the block is idle; the block does not enforce
// this. Its reset value is 1.0. A node with zero or negative density is returned
// unchanged with tuser set.
module d2q9_bgk_node_collision #(
    parameter int VALUE_WIDTH = 24
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_cfg_wr_en,
    input  logic [lbm_pkg::OMEGA_W-1:0] i_cfg_wr_data,
    input  logic i_s_tvalid,
    output logic o_s_tready,
    // pop_rest, pop_east, pop_north, pop_west, pop_south, pop_northeast,
    // pop_northwest, pop_southwest, pop_southeast, force_x, force_y
    input  logic [((11*VALUE_WIDTH+7)/8)*8-1:0] i_s_tdata,
    output logic o_m_tvalid,
    input  logic i_m_tready,
    // new_rest, new_east, new_north, new_west, new_south, new_northeast,
    // new_northwest, new_southwest, new_southeast, density
    output logic [((10*VALUE_WIDTH+7)/8)*8-1:0] o_m_tdata,
    // bad_density
    output logic o_m_tuser
);

    localparam int W       = VALUE_WIDTH;
    localparam int FRAC    = W - lbm_pkg::INT_BITS;
    localparam int ND      = lbm_pkg::NUM_DIR;
    localparam int OW      = lbm_pkg::OMEGA_W;
    localparam int DIV_LAT = W + 2;
    localparam int ST_DIV  = 2 + DIV_LAT;
    localparam int ST_A    = ST_DIV + 1;
    localparam int ST_C    = ST_DIV + 3;
    localparam int ST_F    = ST_DIV + 6;
    localparam int ST_G    = ST_DIV + 7;
    localparam int ST_H    = ST_DIV + 8;

    localparam longint W_REST_L = ((longint'(8) << FRAC) + 9) / 18;
    localparam longint W_AXIS_L = ((longint'(2) << FRAC) + 9) / 18;
    localparam longint W_DIAG_L = ((longint'(2) << FRAC) + 36) / 72;

    typedef logic signed [W-1:0] t_val;
    typedef struct packed {
        logic [ND-1:0][W-1:0] f;
        logic [W-1:0]         rho;
        logic                 bad;
    } t_pl;

    localparam t_val W_REST  = W'(W_REST_L);
    localparam t_val W_AXIS  = W'(W_AXIS_L);
    localparam t_val W_DIAG  = W'(W_DIAG_L);
    localparam t_val ONE_Q   = W'(longint'(1) << FRAC);
    localparam t_val C_THREE = W'(longint'(3) << (FRAC - 1));
    localparam t_val C_NINE  = W'(longint'(9) << (FRAC - 1));
    localparam t_val MAXV    = {1'b0, {(W-1){1'b1}}};
    localparam t_val MINV    = {1'b1, {(W-1){1'b0}}};

    function automatic t_val sat_w(input logic signed [W+5:0] v);
        if (v[W+5:W-1] == '0 || v[W+5:W-1] == '1) begin
            return v[W-1:0];
        end else if (v[W+5]) begin
            return MINV;
        end
        return MAXV;
    endfunction

    function automatic t_val sat_mag(input logic neg, input logic [W+3:0] m);
        logic [W+3:0] nm;
        nm = -m;
        if (neg) begin
            if (m > ((W+4)'(1) << (W-1))) begin
                return MINV;
            end
            return nm[W-1:0];
        end
        if (m[W+3:W-1] != '0) begin
            return MAXV;
        end
        return m[W-1:0];
    endfunction

    // Q(FRAC) product, rounded to nearest with ties away from zero, saturated.
    function automatic t_val mul_q(input t_val a, input t_val b);
        logic [W-1:0]   ma;
        logic [W-1:0]   mb;
        logic [2*W-1:0] p;
        ma = a[W-1] ? W'(-a) : W'(a);
        mb = b[W-1] ? W'(-b) : W'(b);
        p  = (2*W)'(ma) * (2*W)'(mb) + ((2*W)'(1) << (FRAC - 1));
        return sat_mag(a[W-1] ^ b[W-1], p[2*W-1:FRAC]);
    endfunction

    function automatic t_val weight_of(input int k);
        if (k == 0) begin
            return W_REST;
        end else if (k < 5) begin
            return W_AXIS;
        end
        return W_DIAG;
    endfunction

    function automatic logic signed [W+5:0] dir_mul(input logic signed [1:0] d, input t_val v);
        if (d == 2'sd1) begin
            return (W+6)'(v);
        end else if (d == -2'sd1) begin
            return -(W+6)'(v);
        end
        return '0;
    endfunction

    logic [OW-1:0] r_relax_rate;
    logic          r_vld [0:ST_H];
    logic          en;

    // Stage 0: input capture.
    t_val r_f0 [0:ND-1];
    t_val r_fx0, r_fy0;
    // Stage 1: density and momentum.
    t_pl  r_pl [1:ST_G];
    logic signed [W+2:0] r_momx1, r_momy1;
    t_val r_fx1, r_fy1;
    // Stage 2: divider operands.
    logic [W+1:0]     r_nux2, r_nuy2;
    logic             r_negux2, r_neguy2, r_negsx2, r_negsy2;
    logic [W+OW-3:0]  r_nsx2, r_nsy2;
    logic [W+OW-1:0]  r_den2;
    t_val w_ux, w_uy, w_sx, w_sy;
    // Stages A to G.
    t_val r_vx, r_vy;
    t_val r_sqx, r_sqy;
    t_val r_cu_b [0:ND-1];
    t_val r_usq;
    t_val r_cu_c [0:ND-1];
    t_val r_cu2 [0:ND-1];
    t_val r_cu_d [0:ND-1];
    t_val r_a [0:ND-1];
    t_val r_b;
    t_val r_wr_d [0:ND-1];
    t_val r_poly [0:ND-1];
    t_val r_wr_e [0:ND-1];
    t_val r_feq [0:ND-1];
    logic [W+OW:0] r_prod [0:ND-1];
    logic          r_dneg [0:ND-1];
    // Stage H: output.
    t_val r_out_new [0:ND-1];
    t_val r_out_rho;
    logic r_out_bad;

    assign en         = !r_vld[ST_H] || i_m_tready;
    assign o_s_tready = en;
    assign o_m_tvalid = r_vld[ST_H];
    assign o_m_tuser  = r_out_bad;

    always_comb begin
        o_m_tdata = '0;
        for (int k = 0; k < ND; k++) begin
            o_m_tdata[k*W +: W] = r_out_new[k];
        end
        o_m_tdata[ND*W +: W] = r_out_rho;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_relax_rate <= lbm_pkg::RELAX_RATE_RESET;
        end else if (i_cfg_wr_en) begin
            r_relax_rate <= i_cfg_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s <= ST_H; s++) begin
                r_vld[s] <= 1'b0;
            end
        end else if (en) begin
            r_vld[0] <= i_s_tvalid;
            for (int s = 1; s <= ST_H; s++) begin
                r_vld[s] <= r_vld[s-1];
            end
        end
    end

    // Stage 1 logic.
    logic signed [W+3:0] n_sum;
    logic signed [W+2:0] n_momx, n_momy;
    always_comb begin
        n_sum = '0;
        for (int k = 0; k < ND; k++) begin
            n_sum = n_sum + (W+4)'(r_f0[k]);
        end
        n_momx = (W+3)'(r_f0[1]) - (W+3)'(r_f0[3]) + (W+3)'(r_f0[5])
               - (W+3)'(r_f0[6]) - (W+3)'(r_f0[7]) + (W+3)'(r_f0[8]);
        n_momy = (W+3)'(r_f0[2]) - (W+3)'(r_f0[4]) + (W+3)'(r_f0[5])
               + (W+3)'(r_f0[6]) - (W+3)'(r_f0[7]) - (W+3)'(r_f0[8]);
    end

    // Stage 2 logic.
    logic [W+2:0] n_amx, n_amy;
    logic [W-1:0] n_afx, n_afy;
    always_comb begin
        n_amx = r_momx1[W+2] ? -r_momx1 : r_momx1;
        n_amy = r_momy1[W+2] ? -r_momy1 : r_momy1;
        n_afx = r_fx1[W-1] ? W'(-r_fx1) : W'(r_fx1);
        n_afy = r_fy1[W-1] ? W'(-r_fy1) : W'(r_fy1);
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < ND; k++) begin
                r_f0[k] <= i_s_tdata[k*W +: W];
            end
            r_fx0 <= i_s_tdata[ND*W +: W];
            r_fy0 <= i_s_tdata[(ND+1)*W +: W];

            for (int k = 0; k < ND; k++) begin
                r_pl[1].f[k] <= r_f0[k];
            end
            r_pl[1].rho <= sat_w((W+6)'(n_sum));
            r_pl[1].bad <= n_sum[W+3] || (n_sum == '0);
            r_momx1 <= n_momx;
            r_momy1 <= n_momy;
            r_fx1   <= r_fx0;
            r_fy1   <= r_fy0;

            for (int s = 2; s <= ST_G; s++) begin
                r_pl[s] <= r_pl[s-1];
            end

            r_nux2   <= n_amx[W+1:0];
            r_nuy2   <= n_amy[W+1:0];
            r_negux2 <= r_momx1[W+2];
            r_neguy2 <= r_momy1[W+2];
            r_nsx2   <= {n_afx, {lbm_pkg::OMEGA_FRAC{1'b0}}};
            r_nsy2   <= {n_afy, {lbm_pkg::OMEGA_FRAC{1'b0}}};
            r_negsx2 <= r_fx1[W-1];
            r_negsy2 <= r_fy1[W-1];
            r_den2   <= (W+OW)'(r_relax_rate) * (W+OW)'(r_pl[1].rho);
        end
    end

    lbm_div_pipe #(.NUM_W(W+2), .DEN_W(W), .QUO_W(W)) u_div_ux (
        .i_clk(i_clk), .i_en(en), .i_num(r_nux2), .i_den(r_pl[2].rho),
        .i_neg(r_negux2), .o_quo(w_ux)
    );
    lbm_div_pipe #(.NUM_W(W+2), .DEN_W(W), .QUO_W(W)) u_div_uy (
        .i_clk(i_clk), .i_en(en), .i_num(r_nuy2), .i_den(r_pl[2].rho),
        .i_neg(r_neguy2), .o_quo(w_uy)
    );
    lbm_div_pipe #(.NUM_W(W+OW-2), .DEN_W(W+OW), .QUO_W(W)) u_div_sx (
        .i_clk(i_clk), .i_en(en), .i_num(r_nsx2), .i_den(r_den2),
        .i_neg(r_negsx2), .o_quo(w_sx)
    );
    lbm_div_pipe #(.NUM_W(W+OW-2), .DEN_W(W+OW), .QUO_W(W)) u_div_sy (
        .i_clk(i_clk), .i_en(en), .i_num(r_nsy2), .i_den(r_den2),
        .i_neg(r_negsy2), .o_quo(w_sy)
    );

    // With omega zero the velocity shift is dropped.
    logic omega_zero;
    assign omega_zero = (r_relax_rate == '0);

    always_ff @(posedge i_clk) begin
        logic signed [W:0]    diff;
        logic [W:0]           adiff;
        logic [W+OW:0]        rnd;
        logic [W+2:0]         rr;
        logic signed [W+5:0]  nv;
        if (en) begin
            // Stage A: shifted velocity.
            r_vx <= sat_w((W+6)'(w_ux) + (omega_zero ? '0 : (W+6)'(w_sx)));
            r_vy <= sat_w((W+6)'(w_uy) + (omega_zero ? '0 : (W+6)'(w_sy)));
            // Stage B: squares and c.u.
            r_sqx <= mul_q(r_vx, r_vx);
            r_sqy <= mul_q(r_vy, r_vy);
            for (int k = 0; k < ND; k++) begin
                r_cu_b[k] <= sat_w(dir_mul(lbm_pkg::DIR_X[k], r_vx)
                                 + dir_mul(lbm_pkg::DIR_Y[k], r_vy));
            end
            // Stage C.
            r_usq <= sat_w((W+6)'(r_sqx) + (W+6)'(r_sqy));
            for (int k = 0; k < ND; k++) begin
                r_cu2[k]  <= mul_q(r_cu_b[k], r_cu_b[k]);
                r_cu_c[k] <= r_cu_b[k];
            end
            // Stage D.
            r_b <= mul_q(C_THREE, r_usq);
            for (int k = 0; k < ND; k++) begin
                r_a[k]    <= mul_q(C_NINE, r_cu2[k]);
                r_cu_d[k] <= r_cu_c[k];
                r_wr_d[k] <= mul_q(weight_of(k), r_pl[ST_C].rho);
            end
            // Stage E: bracketed polynomial.
            for (int k = 0; k < ND; k++) begin
                r_poly[k] <= sat_w((W+6)'(ONE_Q) + (W+6)'(3) * (W+6)'(r_cu_d[k])
                                 + (W+6)'(r_a[k]) - (W+6)'(r_b));
                r_wr_e[k] <= r_wr_d[k];
            end
            // Stage F: equilibrium.
            for (int k = 0; k < ND; k++) begin
                r_feq[k] <= mul_q(r_wr_e[k], r_poly[k]);
            end
            // Stage G: omega times the distance to equilibrium.
            for (int k = 0; k < ND; k++) begin
                diff  = (W+1)'(r_feq[k]) - (W+1)'($signed(r_pl[ST_F].f[k]));
                adiff = diff[W] ? -diff : diff;
                r_prod[k] <= (W+OW+1)'(adiff) * (W+OW+1)'(r_relax_rate);
                r_dneg[k] <= diff[W];
            end
            // Stage H: relaxation, rounded, saturated.
            for (int k = 0; k < ND; k++) begin
                rnd = r_prod[k] + ((W+OW+1)'(1) << (lbm_pkg::OMEGA_FRAC - 1));
                rr  = rnd[W+OW:lbm_pkg::OMEGA_FRAC];
                if (r_dneg[k]) begin
                    nv = (W+6)'($signed(r_pl[ST_G].f[k])) - $signed((W+6)'(rr));
                end else begin
                    nv = (W+6)'($signed(r_pl[ST_G].f[k])) + $signed((W+6)'(rr));
                end
                r_out_new[k] <= r_pl[ST_G].bad ? t_val'(r_pl[ST_G].f[k]) : sat_w(nv);
            end
            r_out_rho <= r_pl[ST_G].rho;
            r_out_bad <= r_pl[ST_G].bad;
        end
    end

    a_bad_means_nonpositive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser |-> r_out_rho[W-1] || (r_out_rho == '0))
        else $error("bad density flagged on a positive density");

    a_ready_when_out_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_vld[ST_H] |-> o_s_tready)
        else $error("input stalled with an empty output stage");

    a_item_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready |=> r_vld[0])
        else $error("accepted item lost at pipeline entry");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !en && r_vld[ST_A] |=> r_vld[ST_A] && $stable(r_vx))
        else $error("pipeline moved during a stall");

endmodule

@@ hdl/lbm_div_pipe.sv @@
`timescale 1ns / 1ps

// Pipelined restoring divider: saturated (num * 2^(QUO_W-4)) / den, truncated,
// with the sign applied at the end. One quotient bit per stage.
module lbm_div_pipe #(
    parameter int NUM_W = 26,
    parameter int DEN_W = 24,
    parameter int QUO_W = 24
) (
    input  logic                    i_clk,
    input  logic                    i_en,
    input  logic [NUM_W-1:0]        i_num,
    input  logic [DEN_W-1:0]        i_den,
    input  logic                    i_neg,
    output logic signed [QUO_W-1:0] o_quo
);

    localparam int CW = NUM_W + DEN_W + lbm_pkg::INT_BITS;

    logic [DEN_W-1:0] r_rem [0:QUO_W-1];
    logic [QUO_W-1:0] r_low [0:QUO_W-1];
    logic [QUO_W-1:0] r_q   [0:QUO_W];
    logic [DEN_W-1:0] r_den [0:QUO_W-1];
    logic             r_neg [0:QUO_W];
    logic             r_ovf [0:QUO_W];
    logic signed [QUO_W-1:0] r_quo;

    logic [DEN_W-1:0] n_rem [0:QUO_W-1];
    logic             n_bit [0:QUO_W-1];
    logic             n_ovf;
    logic signed [QUO_W-1:0] n_quo;

    // The quotient fits in QUO_W bits exactly when num < 16 * den.
    assign n_ovf = (CW'(i_num) >= (CW'(i_den) << lbm_pkg::INT_BITS));

    always_comb begin
        logic [DEN_W:0] rem2;
        logic [DEN_W:0] diff;
        for (int i = 0; i < QUO_W; i++) begin
            rem2 = {r_rem[i], r_low[i][QUO_W-1]};
            diff = rem2 - {1'b0, r_den[i]};
            n_bit[i] = (rem2 >= {1'b0, r_den[i]});
            n_rem[i] = n_bit[i] ? diff[DEN_W-1:0] : rem2[DEN_W-1:0];
        end
    end

    always_comb begin
        logic [QUO_W-1:0] q;
        logic [QUO_W-1:0] nq;
        q  = r_q[QUO_W];
        nq = -q;
        if (r_neg[QUO_W]) begin
            if (r_ovf[QUO_W] || q > ({{(QUO_W-1){1'b0}}, 1'b1} << (QUO_W-1))) begin
                n_quo = {1'b1, {(QUO_W-1){1'b0}}};
            end else begin
                n_quo = nq;
            end
        end else begin
            if (r_ovf[QUO_W] || q[QUO_W-1]) begin
                n_quo = {1'b0, {(QUO_W-1){1'b1}}};
            end else begin
                n_quo = q;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= DEN_W'(i_num >> lbm_pkg::INT_BITS);
            r_low[0] <= {i_num[lbm_pkg::INT_BITS-1:0], {(QUO_W-lbm_pkg::INT_BITS){1'b0}}};
            r_q[0]   <= '0;
            r_den[0] <= i_den;
            r_neg[0] <= i_neg;
            r_ovf[0] <= n_ovf;
            for (int i = 0; i < QUO_W; i++) begin
                if (i < QUO_W - 1) begin
                    r_rem[i+1] <= n_rem[i];
                    r_low[i+1] <= r_low[i] << 1;
                    r_den[i+1] <= r_den[i];
                end
                r_q[i+1]   <= {r_q[i][QUO_W-2:0], n_bit[i]};
                r_neg[i+1] <= r_neg[i];
                r_ovf[i+1] <= r_ovf[i];
            end
            r_quo <= n_quo;
        end
    end

    assign o_quo = r_quo;

endmodule

@@ test/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;

    localparam int VW      = 24;
    localparam int FR      = VW - 4;
    localparam int IN_W    = ((11*VW+7)/8)*8;
    localparam int OUT_W   = ((10*VW+7)/8)*8;
    localparam int LATENCY = VW + 13;
    localparam longint MAXV = (longint'(1) << (VW-1)) - 1;
    localparam longint MINV = -MAXV - 1;
    localparam longint ONE_Q = longint'(1) << FR;
    localparam longint C_3_2 = longint'(3) << (FR-1);
    localparam longint C_9_2 = longint'(9) << (FR-1);
    localparam longint W_REST = ((longint'(8) << FR) + 9) / 18;
    localparam longint W_AXIS = ((longint'(2) << FR) + 9) / 18;
    localparam longint W_DIAG = ((longint'(2) << FR) + 36) / 72;
    localparam int CYCLE_LIMIT = 600000;

    typedef struct {
        logic [OUT_W-1:0] nodes;
        logic             bad;
    } t_node_result;

    class collision_board;
        t_node_result expected_q[$];
        longint unsigned omega;
        int errors;

        function new();
            omega  = lbm_pkg::RELAX_RATE_RESET;
            errors = 0;
        endfunction

        function longint sat(longint v);
            if (v > MAXV) return MAXV;
            if (v < MINV) return MINV;
            return v;
        endfunction

        function longint sat_mag(bit neg, longint unsigned m);
            if (neg) return (m > longint'(MAXV) + 1) ? MINV : -longint'(m);
            return (m > MAXV) ? MAXV : longint'(m);
        endfunction

        function longint unsigned mag(longint v);
            return (v < 0) ? longint'(-v) : v;
        endfunction

        function longint mul_q(longint a, longint b);
            longint unsigned p;
            p = mag(a) * mag(b);
            return sat_mag((a < 0) != (b < 0), (p + (longint'(1) << (FR-1))) >> FR);
        endfunction

        // Quotient truncated toward zero; the full quotient saturates the same
        // way the bit-serial divider does since it only grows.
        function longint div_q(bit neg, longint unsigned n, longint unsigned d);
            return sat_mag(neg, (n << FR) / d);
        endfunction

        function longint scale_omega(longint d, longint unsigned om);
            longint unsigned r;
            r = (mag(d) * om + (longint'(1) << (lbm_pkg::OMEGA_FRAC-1)))
                >> lbm_pkg::OMEGA_FRAC;
            return (d < 0) ? -longint'(r) : longint'(r);
        endfunction

        function void note_item(logic [IN_W-1:0] d);
            longint f[9];
            longint fx, fy, sum, rho, momx, momy, ux, uy, sx, sy, vx, vy, usq;
            longint cu, poly, wr, feq, nv, wt;
            t_node_result res;
            sum = 0;
            for (int k = 0; k < 9; k++) begin
                f[k] = longint'($signed(d[k*VW +: VW]));
                sum += f[k];
            end
            fx = longint'($signed(d[9*VW +: VW]));
            fy = longint'($signed(d[10*VW +: VW]));
            rho = sat(sum);
            res.nodes = '0;
            res.nodes[9*VW +: VW] = rho[VW-1:0];
            if (rho <= 0) begin
                for (int k = 0; k < 9; k++) res.nodes[k*VW +: VW] = f[k][VW-1:0];
                res.bad = 1'b1;
                expected_q.push_back(res);
                return;
            end
            momx = f[1] - f[3] + f[5] - f[6] - f[7] + f[8];
            momy = f[2] - f[4] + f[5] + f[6] - f[7] - f[8];
            ux = div_q(momx < 0, mag(momx), rho);
            uy = div_q(momy < 0, mag(momy), rho);
            sx = 0;
            sy = 0;
            if (omega != 0) begin
                sx = div_q(fx < 0, mag(fx) << lbm_pkg::OMEGA_FRAC, omega * rho);
                sy = div_q(fy < 0, mag(fy) << lbm_pkg::OMEGA_FRAC, omega * rho);
            end
            vx = sat(ux + sx);
            vy = sat(uy + sy);
            usq = sat(mul_q(vx, vx) + mul_q(vy, vy));
            for (int k = 0; k < 9; k++) begin
                wt = (k == 0) ? W_REST : (k < 5) ? W_AXIS : W_DIAG;
                cu = sat(longint'(lbm_pkg::DIR_X[k]) * vx + longint'(lbm_pkg::DIR_Y[k]) * vy);
                poly = sat(ONE_Q + 3 * cu + mul_q(C_9_2, mul_q(cu, cu)) - mul_q(C_3_2, usq));
                wr = mul_q(wt, rho);
                feq = mul_q(wr, poly);
                nv = sat(f[k] + scale_omega(feq - f[k], omega));
                res.nodes[k*VW +: VW] = nv[VW-1:0];
            end
            res.bad = 1'b0;
            expected_q.push_back(res);
        endfunction

        function void check_result(logic [OUT_W-1:0] d, logic bad);
            t_node_result e;
            string names[10] = '{"new_rest", "new_east", "new_north", "new_west",
                "new_south", "new_northeast", "new_northwest", "new_southwest",
                "new_southeast", "density"};
            if (expected_q.size() == 0) begin
                $error("unexpected result item %h", d);
                errors++;
                return;
            end
            e = expected_q.pop_front();
            for (int k = 0; k < 10; k++) begin
                if (d[k*VW +: VW] !== e.nodes[k*VW +: VW]) begin
                    $error("%s: expected %0d, got %0d", names[k],
                        $signed(e.nodes[k*VW +: VW]), $signed(d[k*VW +: VW]));
                    errors++;
                end
            end
            if (bad !== e.bad) begin
                $error("bad_density: expected %0d, got %0d", e.bad, bad);
                errors++;
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic cfg_wr_en = 1'b0;
    logic [lbm_pkg::OMEGA_W-1:0] cfg_wr_data = '0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [IN_W-1:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [OUT_W-1:0] m_tdata;
    logic m_tuser;

    collision_board board;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_left = 0;
    int cycles = 0;

    always #2 i_clk = ~i_clk;

    d2q9_bgk_node_collision #(.VALUE_WIDTH(VW)) u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_wr_en  (cfg_wr_en),
        .i_cfg_wr_data(cfg_wr_data),
        .i_s_tvalid   (s_tvalid),
        .o_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .o_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .o_m_tdata    (m_tdata),
        .o_m_tuser    (m_tuser)
    );

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb_top: done, errors");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_tvalid && m_tready) board.check_result(m_tdata, m_tuser);
        if (!i_rst_n) begin
            m_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic send_node(input logic [IN_W-1:0] d);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= d;
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
        board.note_item(d);
    endtask

    task automatic drain_and_set_omega(input logic [lbm_pkg::OMEGA_W-1:0] om);
        s_tvalid <= 1'b0;
        while (board.expected_q.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 4) @(posedge i_clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= om;
        @(posedge i_clk);
        cfg_wr_en <= 1'b0;
        board.omega = om;
        @(posedge i_clk);
    endtask

    function automatic logic [IN_W-1:0] pack_node(logic [VW-1:0] v[11]);
        logic [IN_W-1:0] d;
        d = '0;
        for (int k = 0; k < 11; k++) d[k*VW +: VW] = v[k];
        return d;
    endfunction

    // Mostly physical nodes: non-negative distributions up to one half with
    // small forces; the rest is moderate signed noise or raw full-range noise.
    function automatic logic [IN_W-1:0] random_node();
        logic [VW-1:0] v[11];
        int mode;
        mode = $urandom_range(9);
        for (int k = 0; k < 11; k++) begin
            if (mode < 7) begin
                if (k < 9) v[k] = VW'($urandom_range(1 << (FR-1)));
                else v[k] = VW'($signed($urandom_range(1 << 16)) - (1 << 15));
            end else if (mode < 9) begin
                v[k] = VW'($signed($urandom_range(1 << 22)) - (1 << 20));
            end else begin
                v[k] = VW'($urandom);
            end
        end
        return pack_node(v);
    endfunction

    task automatic run_directed();
        logic [VW-1:0] v[11];
        for (int t = 0; t < 14; t++) begin
            for (int k = 0; k < 11; k++) begin
                case (t)
                    0: v[k] = '0;
                    1: v[k] = MAXV[VW-1:0];
                    2: v[k] = MINV[VW-1:0];
                    3: v[k] = (k == 0) ? W_REST[VW-1:0] : (k < 5) ? W_AXIS[VW-1:0]
                              : (k < 9) ? W_DIAG[VW-1:0] : '0;
                    4: v[k] = (k < 9) ? VW'(1) : MAXV[VW-1:0];
                    5: v[k] = (k < 9) ? VW'(1) : MINV[VW-1:0];
                    6: v[k] = (k == 1 || k == 5 || k == 8) ? MAXV[VW-1:0] : '0;
                    7: v[k] = (k == 3 || k == 6 || k == 7) ? MAXV[VW-1:0]
                              : (k == 0) ? VW'(1) : '0;
                    8: v[k] = (k == 0) ? VW'(3 << FR) : (k == 4) ? VW'(-(2 << FR)) : '0;
                    9: v[k] = (k == 0) ? VW'(1) : '0;
                    10: v[k] = (k == 2) ? VW'(-1) : (k == 0) ? VW'(1) : '0;
                    11: v[k] = (k == 2 || k == 5 || k == 6) ? MAXV[VW-1:0] : '0;
                    12: v[k] = (k < 9) ? VW'(1 << (FR-3)) : VW'(1 << FR);
                    default: v[k] = VW'($urandom);
                endcase
            end
            send_node(pack_node(v));
        end
    endtask

    task automatic run_random(input int n, input int s_pct, input int r_pct);
        send_idle_pct  = s_pct;
        recv_stall_pct = r_pct;
        for (int i = 0; i < n; i++) send_node(random_node());
    endtask

    initial begin
        board = new();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        run_directed();
        run_random(250, 0, 0);
        drain_and_set_omega(16'd0);
        run_directed();
        run_random(200, 86, 0);
        drain_and_set_omega(16'd32768);
        run_directed();
        run_random(200, 0, 86);
        drain_and_set_omega(16'hFFFF);
        run_random(150, 29, 29);
        drain_and_set_omega(16'd1);
        run_random(150, 29, 29);
        drain_and_set_omega(16'h5555);
        run_random(150, 0, 0);
        drain_and_set_omega(16'hAAAA & 16'h7FFF);

        // Long receiver hold-off while the sender keeps offering items, so
        // the pipeline fills and back-pressure reaches the input.
        hold_left = 400;
        run_random(120, 0, 0);
        drain_and_set_omega(16'($urandom_range(32768)));
        run_random(150, 29, 29);
        drain_and_set_omega(16'd16384);
        run_random(100, 0, 0);

        s_tvalid <= 1'b0;
        while (board.expected_q.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 10) @(posedge i_clk);
        if (board.errors == 0) begin
            $display("tb_top: done, clean");
        end else begin
            $display("tb_top: done, errors");
        end
        $finish;
    end

endmodule
